// ----- src/assert_macros.svh -----
// assertion macros used by the divider rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define WSD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define WSD_ASSERT(lbl, prop, msg)
`define WSD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- src/wsd_pkg.sv -----
// shared constants, types and status codes of the signed divider
`default_nettype none
package wsd_pkg;
    localparam int WIDTH   = 64;
    localparam int FIELD_W = 64;
    localparam int CNT_W   = $clog2(WIDTH);
    localparam int SUB_W   = WIDTH + 1;
    localparam int STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_DIV0 = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVF  = 2'd2;

    localparam logic [WIDTH-1:0] MIN_VAL = WIDTH'(1) << (WIDTH - 1);
    localparam logic [WIDTH-1:0] ALL_ONES = '1;
    localparam logic signed [FIELD_W-1:0] MIN_EXT = FIELD_W'($signed(MIN_VAL));

    typedef struct packed {
        logic signed [FIELD_W-1:0] dividend;
        logic signed [FIELD_W-1:0] divisor;
    } t_req;

    typedef struct packed {
        logic signed [FIELD_W-1:0] quotient;
        logic signed [FIELD_W-1:0] remainder;
        logic [STAT_W-1:0]         status;
    } t_rsp;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;
endpackage
`default_nettype wire

// ----- src/wsd_sub.sv -----
// shared subtractor used for negation and trial subtraction
`default_nettype none
module wsd_sub (
    input  wire logic [wsd_pkg::SUB_W-1:0] i_op_a,
    input  wire logic [wsd_pkg::SUB_W-1:0] i_op_b,
    output logic      [wsd_pkg::SUB_W-1:0] o_diff,
    output logic                           o_borrow
);
    import wsd_pkg::*;

    logic [SUB_W:0] w_full;

    assign w_full   = {1'b0, i_op_a} - {1'b0, i_op_b};
    assign o_diff   = w_full[SUB_W-1:0];
    assign o_borrow = w_full[SUB_W];
endmodule
`default_nettype wire

// ----- src/wsd_engine.sv -----
// sequencer and datapath registers of the shift-and-subtract divider
`default_nettype none
module wsd_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire wsd_pkg::t_req      i_req,
    input  wire logic               i_take,
    output wsd_pkg::t_eng_stat      o_stat,
    output wsd_pkg::t_rsp           o_rsp
);
    import wsd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NEGA = 3'd1;
    localparam logic [2:0] S_NEGB = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIXR = 3'd4;
    localparam logic [2:0] S_FIXQ = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [WIDTH-1:0]  r_quo, n_quo;
    logic [WIDTH-1:0]  r_rem, n_rem;
    logic [WIDTH-1:0]  r_div, n_div;
    logic              r_a_neg, n_a_neg;
    logic              r_q_neg, n_q_neg;
    logic [STAT_W-1:0] r_status, n_status;

    logic [SUB_W-1:0]  w_op_a;
    logic [SUB_W-1:0]  w_op_b;
    logic [SUB_W-1:0]  w_diff;
    logic              w_borrow;
    logic [WIDTH-1:0]  w_a;
    logic [WIDTH-1:0]  w_b;

    wsd_sub u_sub (
        .i_op_a   (w_op_a),
        .i_op_b   (w_op_b),
        .o_diff   (w_diff),
        .o_borrow (w_borrow)
    );

    assign w_a = i_req.dividend[WIDTH-1:0];
    assign w_b = i_req.divisor[WIDTH-1:0];

    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_state)
            S_NEGA: w_op_b = {1'b0, r_quo};
            S_NEGB: w_op_b = {1'b0, r_div};
            S_DIV: begin
                w_op_a = {r_rem, r_quo[WIDTH-1]};
                w_op_b = {1'b0, r_div};
            end
            S_FIXR: w_op_b = {1'b0, r_rem};
            S_FIXQ: w_op_b = {1'b0, r_quo};
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_div    = r_div;
        n_a_neg  = r_a_neg;
        n_q_neg  = r_q_neg;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_quo   = w_a;
                    n_div   = w_b;
                    n_rem   = '0;
                    n_a_neg = w_a[WIDTH-1];
                    n_q_neg = w_a[WIDTH-1] ^ w_b[WIDTH-1];
                    if (w_b == '0) begin
                        n_quo    = '0;
                        n_status = ST_DIV0;
                        n_state  = S_DONE;
                    end else begin
                        n_status = (w_a == MIN_VAL && w_b == ALL_ONES) ? ST_OVF : ST_OK;
                        n_state  = S_NEGA;
                    end
                end
            end
            S_NEGA: begin
                if (r_a_neg) begin
                    n_quo = w_diff[WIDTH-1:0];
                end
                n_state = S_NEGB;
            end
            S_NEGB: begin
                if (r_div[WIDTH-1]) begin
                    n_div = w_diff[WIDTH-1:0];
                end
                n_cnt   = CNT_W'(WIDTH - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!w_borrow) begin
                    n_rem = w_diff[WIDTH-1:0];
                end else begin
                    n_rem = w_op_a[WIDTH-1:0];
                end
                n_quo = {r_quo[WIDTH-2:0], !w_borrow};
                if (r_cnt == '0) begin
                    n_state = S_FIXR;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_FIXR: begin
                if (r_a_neg) begin
                    n_rem = w_diff[WIDTH-1:0];
                end
                n_state = S_FIXQ;
            end
            S_FIXQ: begin
                if (r_q_neg) begin
                    n_quo = w_diff[WIDTH-1:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_a_neg  <= n_a_neg;
        r_q_neg  <= n_q_neg;
        r_status <= n_status;
    end

    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.done     = (r_state == S_DONE);
    assign o_rsp.quotient  = FIELD_W'($signed(r_quo));
    assign o_rsp.remainder = FIELD_W'($signed(r_rem));
    assign o_rsp.status    = r_status;
endmodule
`default_nettype wire

// ----- src/wide_signed_divider_core.sv -----
// signed truncating divider: request/response wrapper around the radix-2 engine
// usage:
//   request channel: i_req_valid with i_req (dividend, divisor); accepted when
//   i_req_valid is high and o_req_stall is low. only the low WIDTH bits count.
//   response channel: o_rsp_valid with o_rsp (quotient, remainder, status);
//   taken when o_rsp_valid is high and i_rsp_stall is low.
//   sequence: an accepted request goes through S_NEGA and S_NEGB (operand
//   negation), S_DIV, S_FIXR and S_FIXQ (sign fix-up) to S_DONE and then into
//   the output register; a zero divisor goes straight to S_DONE. in S_DIV the
//   shared subtractor does one quotient bit per cycle. o_req_stall stays high
//   while the engine works. a finished response sits in an output register,
//   so a new request may be accepted while the receiver stalls it; the engine
//   then holds its next result until the output register frees up.
//   status: 0 ok, 1 divide by zero (zero results), 2 overflow (wrapped).
//   reset: synchronous active low; clears the sequencer and output valid.
`default_nettype none
`include "assert_macros.svh"
module wide_signed_divider_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_stall,
    input  wire wsd_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_stall,
    output wsd_pkg::t_rsp      o_rsp
);
    import wsd_pkg::*;

    t_eng_stat w_stat;
    t_rsp      w_eng_rsp;
    logic      w_start;
    logic      w_take;
    logic      r_rsp_valid;
    t_rsp      r_rsp;
    logic      w_rsp_div0;
    logic      w_rsp_ovf;
    logic      w_quo_zero;
    logic      w_quo_min;
    logic      w_rem_zero;

    assign o_req_stall = !w_stat.idle;
    assign w_start     = i_req_valid && w_stat.idle;
    assign w_take      = w_stat.done && (!r_rsp_valid || !i_rsp_stall);

    wsd_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (i_req),
        .i_take  (w_take),
        .o_stat  (w_stat),
        .o_rsp   (w_eng_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_take) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rsp <= w_eng_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    assign w_rsp_div0 = o_rsp_valid && (o_rsp.status == ST_DIV0);
    assign w_rsp_ovf  = o_rsp_valid && (o_rsp.status == ST_OVF);
    assign w_quo_zero = (o_rsp.quotient == '0);
    assign w_quo_min  = (o_rsp.quotient == MIN_EXT);
    assign w_rem_zero = (o_rsp.remainder == '0);

    `WSD_ASSERT(a_busy_after_req, i_req_valid && !o_req_stall |=> o_req_stall, "busy not raised")
    `WSD_ASSERT(a_div0_zero, w_rsp_div0 |-> w_quo_zero && w_rem_zero, "div0 results not zero")
    `WSD_ASSERT(a_ovf_wrap, w_rsp_ovf |-> w_quo_min && w_rem_zero, "overflow result wrong")
    `WSD_ASSERT_RST(a_rst_clear, !i_rst_n |=> !o_rsp_valid && !o_req_stall, "reset left control set")
endmodule
`default_nettype wire
